// ===== sv/rvu_pkg.sv =====
// Shared constants for the refraction vector unit.
`timescale 1ns / 1ps
`default_nettype none
package rvu_pkg;
   localparam int IDX_W        = 16;
   localparam int FRAC_W       = 30;
   localparam int COS_W        = 31;
   localparam int ETA_W        = 43;
   localparam int OUT_W        = 19;
   localparam int DIV_STEPS    = 43;
   localparam int DIV_PER_STG  = 8;
   localparam int SQRT_STEPS   = 31;
   localparam int SQRT_PER_STG = 4;
   localparam int SQRT_X_W     = 62;
endpackage
`default_nettype wire

// ===== sv/refraction_vector_unit.sv =====
// Top level of the Snell's-law refraction vector unit.
`timescale 1ns / 1ps
`default_nettype none
// Refraction vector unit: one transfer in and one result out per cycle when the
// result side keeps rsp_ready high. The depth from input transfer to rsp_valid
// is set by the 6-stage reciprocal divider for eta, the 8-stage square root of
// k, and the chain of 2-stage multipliers between them. When a
// result is held (rsp_valid high, rsp_ready low) the whole pipeline holds.
module refraction_vector_unit #(
   parameter int VEC_WIDTH = 16
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   output logic                             req_ready,
   input  wire logic signed [VEC_WIDTH-1:0] req_incident_x,
   input  wire logic signed [VEC_WIDTH-1:0] req_incident_y,
   input  wire logic signed [VEC_WIDTH-1:0] req_incident_z,
   input  wire logic signed [VEC_WIDTH-1:0] req_normal_x,
   input  wire logic signed [VEC_WIDTH-1:0] req_normal_y,
   input  wire logic signed [VEC_WIDTH-1:0] req_normal_z,
   input  wire logic [15:0]                 req_refractive_index,
   output logic                             rsp_valid,
   input  wire logic                        rsp_ready,
   output logic signed [18:0]               rsp_refracted_x,
   output logic signed [18:0]               rsp_refracted_y,
   output logic signed [18:0]               rsp_refracted_z,
   output logic                             rsp_internal_reflection,
   output logic                             rsp_saturated
);
   localparam int W     = VEC_WIDTH;
   localparam int LAT   = 25;
   localparam int ETA_W = rvu_pkg::ETA_W;
   localparam int COS_W = rvu_pkg::COS_W;
   localparam int FR    = rvu_pkg::FRAC_W;
   localparam int OUT_W = rvu_pkg::OUT_W;

   logic advance;
   logic [LAT-1:0] valid_ff, valid_in;

   assign advance   = ~valid_ff[LAT-1] | rsp_ready;
   assign req_ready = advance;
   assign rsp_valid = valid_ff[LAT-1];
   assign valid_in  = {valid_ff[LAT-2:0], req_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (advance) begin
         valid_ff <= valid_in;
      end
   end

   // stage 1: magnitudes and signs
   logic [W-1:0] i_raw [3];
   logic [W-1:0] n_raw [3];
   logic [W-1:0] i_mag_ff [3];
   logic [W-1:0] n_mag_ff [3];
   logic [2:0]   i_neg_ff, n_neg_ff;
   logic [15:0]  index_ff;

   assign i_raw[0] = req_incident_x;
   assign i_raw[1] = req_incident_y;
   assign i_raw[2] = req_incident_z;
   assign n_raw[0] = req_normal_x;
   assign n_raw[1] = req_normal_y;
   assign n_raw[2] = req_normal_z;

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int j = 0; j < 3; j++) begin
            i_neg_ff[j] <= i_raw[j][W-1];
            n_neg_ff[j] <= n_raw[j][W-1];
            i_mag_ff[j] <= i_raw[j][W-1] ? W'(-i_raw[j]) : i_raw[j];
            n_mag_ff[j] <= n_raw[j][W-1] ? W'(-n_raw[j]) : n_raw[j];
         end
         index_ff <= (req_refractive_index == 16'd0) ? 16'd1 : req_refractive_index;
      end
   end

   // stages 2-3: dot product terms
   logic [2*W-1:0] dot_prod [3];
   logic [2:0]     dot_neg_d3;

   for (genvar j = 0; j < 3; j++) begin : g_dot
      rvu_mul #(.AW(W), .BW(W)) u_dot_mul (
         .clock(clock), .advance(advance),
         .a(i_mag_ff[j]), .b(n_mag_ff[j]), .product(dot_prod[j])
      );
   end

   rvu_delay #(.WIDTH(3), .DEPTH(2)) u_dot_sign_dly (
      .clock(clock), .advance(advance), .din(i_neg_ff ^ n_neg_ff), .dout(dot_neg_d3)
   );

   // stage 4: clamped cosine and entering/leaving
   logic [63:0]       dot_wide [3];
   logic signed [34:0] dot_term [3];
   logic signed [34:0] dot_sum, dot_clamp;
   logic [COS_W-1:0]   cos_ff, cos_in;
   logic               leave_ff, leave_in;

   always_comb begin
      for (int j = 0; j < 3; j++) begin
         dot_wide[j] = 64'(dot_prod[j]) << (64 - 2 * W);
         dot_term[j] = dot_neg_d3[j] ? -$signed(35'(dot_wide[j][62:30]))
                                     :  $signed(35'(dot_wide[j][62:30]));
      end
      dot_sum = dot_term[0] + dot_term[1] + dot_term[2];
      if (dot_sum > 35'sd1073741824) begin
         dot_clamp = 35'sd1073741824;
      end else if (dot_sum < -35'sd1073741824) begin
         dot_clamp = -35'sd1073741824;
      end else begin
         dot_clamp = dot_sum;
      end
      leave_in = dot_clamp > 35'sd0;
      cos_in   = leave_in ? dot_clamp[COS_W-1:0] : COS_W'(-dot_clamp);
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         cos_ff   <= cos_in;
         leave_ff <= leave_in;
      end
   end

   // stages 5-7: 1 - cos^2
   logic [2*COS_W-1:0] c2_prod;
   logic [COS_W-1:0]   sin2_ff;

   rvu_mul #(.AW(COS_W), .BW(COS_W)) u_c2_mul (
      .clock(clock), .advance(advance), .a(cos_ff), .b(cos_ff), .product(c2_prod)
   );

   always_ff @(posedge clock) begin
      if (advance) begin
         sin2_ff <= (COS_W'(1) << FR) - c2_prod[2*FR:FR];
      end
   end

   // stages 2-8: eta
   logic [ETA_W-1:0] recip_q;
   logic [15:0]      index_d7;
   logic             leave_d7;
   logic [ETA_W-1:0] eta_ff;

   rvu_recip u_recip (
      .clock(clock), .advance(advance), .divisor(index_ff), .quotient(recip_q)
   );

   rvu_delay #(.WIDTH(16), .DEPTH(6)) u_index_dly (
      .clock(clock), .advance(advance), .din(index_ff), .dout(index_d7)
   );

   rvu_delay #(.WIDTH(1), .DEPTH(3)) u_leave7_dly (
      .clock(clock), .advance(advance), .din(leave_ff), .dout(leave_d7)
   );

   always_ff @(posedge clock) begin
      if (advance) begin
         eta_ff <= leave_d7 ? (ETA_W'(index_d7) << 18) : recip_q;
      end
   end

   // stages 9-12: t = eta*sin2, eta*cos, u = eta*t
   logic [COS_W-1:0]       sin2_d8, cos_d8;
   logic [ETA_W+COS_W-1:0] t_prod, ec_prod;
   logic [ETA_W-1:0]       eta_d10;
   logic [2*ETA_W-1:0]     u_prod;

   rvu_delay #(.WIDTH(COS_W), .DEPTH(1)) u_sin2_dly (
      .clock(clock), .advance(advance), .din(sin2_ff), .dout(sin2_d8)
   );

   rvu_delay #(.WIDTH(COS_W), .DEPTH(4)) u_cos_dly (
      .clock(clock), .advance(advance), .din(cos_ff), .dout(cos_d8)
   );

   rvu_mul #(.AW(ETA_W), .BW(COS_W)) u_t_mul (
      .clock(clock), .advance(advance), .a(eta_ff), .b(sin2_d8), .product(t_prod)
   );

   rvu_mul #(.AW(ETA_W), .BW(COS_W)) u_ec_mul (
      .clock(clock), .advance(advance), .a(eta_ff), .b(cos_d8), .product(ec_prod)
   );

   rvu_delay #(.WIDTH(ETA_W), .DEPTH(2)) u_eta10_dly (
      .clock(clock), .advance(advance), .din(eta_ff), .dout(eta_d10)
   );

   rvu_mul #(.AW(ETA_W), .BW(ETA_W)) u_u_mul (
      .clock(clock), .advance(advance), .a(eta_d10),
      .b(t_prod[ETA_W+FR-1:FR]), .product(u_prod)
   );

   // stage 13: total internal reflection test and radicand
   logic [2*ETA_W-FR-1:0] u_val;
   logic                  tir_ff;
   logic [COS_W-1:0]      rad_ff;

   assign u_val = u_prod[2*ETA_W-1:FR];

   always_ff @(posedge clock) begin
      if (advance) begin
         tir_ff <= u_val > ((2*ETA_W-FR)'(1) << FR);
         rad_ff <= (COS_W'(1) << FR) - u_val[COS_W-1:0];
      end
   end

   // stages 14-22: sqrt(k) and coefficient
   logic [COS_W-1:0]   root;
   logic [ETA_W-1:0]   ec_d21;
   logic signed [ETA_W:0] coef_in;
   logic [ETA_W-1:0]   coef_mag_ff;
   logic               coef_neg_ff;

   rvu_sqrt u_sqrt (
      .clock(clock), .advance(advance),
      .radicand(rvu_pkg::SQRT_X_W'({rad_ff, {FR{1'b0}}})), .root(root)
   );

   rvu_delay #(.WIDTH(ETA_W), .DEPTH(11)) u_ec_dly (
      .clock(clock), .advance(advance), .din(ec_prod[ETA_W+FR-1:FR]), .dout(ec_d21)
   );

   assign coef_in = $signed({1'b0, ec_d21}) - $signed((ETA_W+1)'(root));

   always_ff @(posedge clock) begin
      if (advance) begin
         coef_neg_ff <= coef_in[ETA_W];
         coef_mag_ff <= coef_in[ETA_W] ? ETA_W'(-coef_in) : coef_in[ETA_W-1:0];
      end
   end

   // stages 23-24: I*eta and n*coef
   logic [ETA_W-1:0] eta_d22;
   logic [6*W-1:0]   mag_d22;
   logic [5:0]       vneg_d24;
   logic             leave_d24, coef_neg_d24, tir_d24;
   logic [31+ETA_W:0] pi_prod [3];
   logic [31+ETA_W:0] pn_prod [3];

   rvu_delay #(.WIDTH(ETA_W), .DEPTH(14)) u_eta22_dly (
      .clock(clock), .advance(advance), .din(eta_ff), .dout(eta_d22)
   );

   rvu_delay #(.WIDTH(6*W), .DEPTH(21)) u_mag_dly (
      .clock(clock), .advance(advance),
      .din({n_mag_ff[2], n_mag_ff[1], n_mag_ff[0], i_mag_ff[2], i_mag_ff[1], i_mag_ff[0]}),
      .dout(mag_d22)
   );

   rvu_delay #(.WIDTH(6), .DEPTH(23)) u_vneg_dly (
      .clock(clock), .advance(advance), .din({n_neg_ff, i_neg_ff}), .dout(vneg_d24)
   );

   rvu_delay #(.WIDTH(1), .DEPTH(20)) u_leave24_dly (
      .clock(clock), .advance(advance), .din(leave_ff), .dout(leave_d24)
   );

   rvu_delay #(.WIDTH(1), .DEPTH(2)) u_coef_sign_dly (
      .clock(clock), .advance(advance), .din(coef_neg_ff), .dout(coef_neg_d24)
   );

   rvu_delay #(.WIDTH(1), .DEPTH(11)) u_tir_dly (
      .clock(clock), .advance(advance), .din(tir_ff), .dout(tir_d24)
   );

   for (genvar j = 0; j < 3; j++) begin : g_out_mul
      rvu_mul #(.AW(32), .BW(ETA_W)) u_i_mul (
         .clock(clock), .advance(advance),
         .a(32'(mag_d22[j*W +: W]) << (32 - W)), .b(eta_d22), .product(pi_prod[j])
      );
      rvu_mul #(.AW(32), .BW(ETA_W)) u_n_mul (
         .clock(clock), .advance(advance),
         .a(32'(mag_d22[(j+3)*W +: W]) << (32 - W)), .b(coef_mag_ff), .product(pn_prod[j])
      );
   end

   // stage 25: combine, round, saturate
   logic signed [45:0]      v_i [3];
   logic signed [45:0]      v_n [3];
   logic signed [45:0]      v_rnd [3];
   logic signed [29:0]      q_val [3];
   logic signed [OUT_W-1:0] comp_in [3];
   logic signed [OUT_W-1:0] comp_ff [3];
   logic                    sat_in, sat_ff, tir_out_ff;

   always_comb begin
      sat_in = 1'b0;
      for (int j = 0; j < 3; j++) begin
         v_i[j] = vneg_d24[j] ? -$signed(46'(pi_prod[j][73:30]))
                              :  $signed(46'(pi_prod[j][73:30]));
         v_n[j] = (vneg_d24[j+3] ^ leave_d24 ^ coef_neg_d24)
                  ? -$signed(46'(pn_prod[j][73:30])) : $signed(46'(pn_prod[j][73:30]));
         v_rnd[j] = v_i[j] + v_n[j] + 46'sd32768;
         q_val[j] = v_rnd[j][45:16];
         if (q_val[j] > 30'sd262143) begin
            comp_in[j] = 19'sd262143;
            sat_in     = 1'b1;
         end else if (q_val[j] < -30'sd262144) begin
            comp_in[j] = -19'sd262144;
            sat_in     = 1'b1;
         end else begin
            comp_in[j] = q_val[j][OUT_W-1:0];
         end
         if (tir_d24) begin
            comp_in[j] = '0;
         end
      end
      if (tir_d24) begin
         sat_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int j = 0; j < 3; j++) comp_ff[j] <= comp_in[j];
         sat_ff     <= sat_in;
         tir_out_ff <= tir_d24;
      end
   end

   assign rsp_refracted_x         = comp_ff[0];
   assign rsp_refracted_y         = comp_ff[1];
   assign rsp_refracted_z         = comp_ff[2];
   assign rsp_saturated           = sat_ff;
   assign rsp_internal_reflection = tir_out_ff;
endmodule
`default_nettype wire

// ===== sv/rvu_delay.sv =====
// Enabled shift line that carries side data alongside the arithmetic stages.
`timescale 1ns / 1ps
`default_nettype none
module rvu_delay #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 1
) (
   input  wire logic             clock,
   input  wire logic             advance,
   input  wire logic [WIDTH-1:0] din,
   output logic      [WIDTH-1:0] dout
);
   logic [WIDTH-1:0] line_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (advance) begin
         line_ff[0] <= din;
         for (int k = 1; k < DEPTH; k++) line_ff[k] <= line_ff[k-1];
      end
   end

   assign dout = line_ff[DEPTH-1];
endmodule
`default_nettype wire

// ===== sv/rvu_mul.sv =====
// Two-stage unsigned multiplier built from four registered partial products.
`timescale 1ns / 1ps
`default_nettype none
module rvu_mul #(
   parameter int AW = 32,
   parameter int BW = 32
) (
   input  wire logic             clock,
   input  wire logic             advance,
   input  wire logic [AW-1:0]    a,
   input  wire logic [BW-1:0]    b,
   output logic      [AW+BW-1:0] product
);
   localparam int AL = AW / 2;
   localparam int AH = AW - AL;
   localparam int BL = BW / 2;
   localparam int BH = BW - BL;
   localparam int PW = AW + BW;

   logic [AL+BL-1:0] ll_ff;
   logic [AH+BL-1:0] hl_ff;
   logic [AL+BH-1:0] lh_ff;
   logic [AH+BH-1:0] hh_ff;
   logic [PW-1:0]    product_ff, product_in;

   always_comb begin
      product_in = (PW'(hh_ff) << (AL + BL)) + (PW'(hl_ff) << AL)
                 + (PW'(lh_ff) << BL) + PW'(ll_ff);
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         ll_ff      <= (AL+BL)'(a[AL-1:0]) * (AL+BL)'(b[BL-1:0]);
         hl_ff      <= (AH+BL)'(a[AW-1:AL]) * (AH+BL)'(b[BL-1:0]);
         lh_ff      <= (AL+BH)'(a[AL-1:0]) * (AL+BH)'(b[BW-1:BL]);
         hh_ff      <= (AH+BH)'(a[AW-1:AL]) * (AH+BH)'(b[BW-1:BL]);
         product_ff <= product_in;
      end
   end

   assign product = product_ff;
endmodule
`default_nettype wire

// ===== sv/rvu_recip.sv =====
// Pipelined long division giving floor(2^42 / divisor), up to eight quotient bits per stage.
`timescale 1ns / 1ps
`default_nettype none
module rvu_recip (
   input  wire logic                      clock,
   input  wire logic                      advance,
   input  wire logic [rvu_pkg::IDX_W-1:0] divisor,
   output logic      [rvu_pkg::ETA_W-1:0] quotient
);
   localparam int NST = (rvu_pkg::DIV_STEPS + rvu_pkg::DIV_PER_STG - 1) / rvu_pkg::DIV_PER_STG;
   localparam int RW  = rvu_pkg::IDX_W;
   localparam int QW  = rvu_pkg::ETA_W;

   logic [RW-1:0] rem_ff [NST];
   logic [QW-1:0] quo_ff [NST];
   logic [RW-1:0] div_ff [NST];
   logic [RW-1:0] rem_at [NST+1];
   logic [QW-1:0] quo_at [NST+1];
   logic [RW-1:0] div_at [NST+1];

   assign rem_at[0] = '0;
   assign quo_at[0] = '0;
   assign div_at[0] = divisor;

   for (genvar g = 0; g < NST; g++) begin : g_stage
      logic [RW-1:0] rem_in;
      logic [QW-1:0] quo_in;
      logic [RW:0]   wide;

      always_comb begin
         rem_in = rem_at[g];
         quo_in = quo_at[g];
         wide   = '0;
         for (int j = 0; j < rvu_pkg::DIV_PER_STG; j++) begin
            if (g * rvu_pkg::DIV_PER_STG + j < rvu_pkg::DIV_STEPS) begin
               wide = {rem_in, ((g * rvu_pkg::DIV_PER_STG + j) == 0)};
               if (wide >= {1'b0, div_at[g]}) begin
                  rem_in = RW'(wide - {1'b0, div_at[g]});
                  quo_in = {quo_in[QW-2:0], 1'b1};
               end else begin
                  rem_in = wide[RW-1:0];
                  quo_in = {quo_in[QW-2:0], 1'b0};
               end
            end
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            rem_ff[g] <= rem_in;
            quo_ff[g] <= quo_in;
            div_ff[g] <= div_at[g];
         end
      end

      assign rem_at[g+1] = rem_ff[g];
      assign quo_at[g+1] = quo_ff[g];
      assign div_at[g+1] = div_ff[g];
   end

   assign quotient = quo_at[NST];
endmodule
`default_nettype wire

// ===== sv/rvu_sqrt.sv =====
// Pipelined digit-by-digit integer square root, up to four result bits per stage.
`timescale 1ns / 1ps
`default_nettype none
module rvu_sqrt (
   input  wire logic                         clock,
   input  wire logic                         advance,
   input  wire logic [rvu_pkg::SQRT_X_W-1:0] radicand,
   output logic      [rvu_pkg::COS_W-1:0]    root
);
   localparam int NST = (rvu_pkg::SQRT_STEPS + rvu_pkg::SQRT_PER_STG - 1)
                        / rvu_pkg::SQRT_PER_STG;
   localparam int XW  = rvu_pkg::SQRT_X_W;

   logic [XW-1:0] x_ff   [NST];
   logic [XW-1:0] res_ff [NST];
   logic [XW-1:0] x_at   [NST+1];
   logic [XW-1:0] res_at [NST+1];

   assign x_at[0]   = radicand;
   assign res_at[0] = '0;

   for (genvar g = 0; g < NST; g++) begin : g_stage
      logic [XW-1:0] x_in;
      logic [XW-1:0] res_in;
      logic [XW-1:0] trial;
      logic [XW-1:0] bit_w;

      always_comb begin
         x_in   = x_at[g];
         res_in = res_at[g];
         trial  = '0;
         bit_w  = '0;
         for (int j = 0; j < rvu_pkg::SQRT_PER_STG; j++) begin
            if (g * rvu_pkg::SQRT_PER_STG + j < rvu_pkg::SQRT_STEPS) begin
               bit_w = XW'(1) << (2 * (rvu_pkg::SQRT_STEPS - 1
                                       - (g * rvu_pkg::SQRT_PER_STG + j)));
               trial = res_in + bit_w;
               if (x_in >= trial) begin
                  x_in   = x_in - trial;
                  res_in = (res_in >> 1) + bit_w;
               end else begin
                  res_in = res_in >> 1;
               end
            end
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            x_ff[g]   <= x_in;
            res_ff[g] <= res_in;
         end
      end

      assign x_at[g+1]   = x_ff[g];
      assign res_at[g+1] = res_ff[g];
   end

   logic unused_x;
   assign unused_x = ^x_at[NST];
   assign root = res_at[NST][rvu_pkg::COS_W-1:0] | {rvu_pkg::COS_W{unused_x & 1'b0}};
endmodule
`default_nettype wire
